@@ hw/rtl/htk_pkg.sv @@
// Shared types and constants for the read/write hazard dependency tracker.
// No dependencies; used by every module of the block except htk_ram.
package htk_pkg;

    localparam int MAX_TASKS_DEF    = 32;
    localparam int MAX_ACCESSES_DEF = 8;
    localparam int TYPE_ID_BITS_DEF = 16;

    localparam int TYPE_ID_W = 16;
    localparam int INDEX_W   = 5;
    localparam int MASK_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int REQ_W     = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLOSE = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic add;
        logic clear;
        logic close_start;
        logic close_full;
        logic rd_issue;
        logic store;
        logic load_out;
    } htk_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic tc_zero;
        logic scan_last;
    } htk_stat_t;

endpackage

@@ hw/rtl/htk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/htk_datapath.sv @@
// Datapath: open-task lanes, task table RAM, conflict compare, result registers.
// Depends on htk_pkg and htk_ram.
module htk_datapath #(
    parameter int MAX_TASKS    = htk_pkg::MAX_TASKS_DEF,
    parameter int MAX_ACCESSES = htk_pkg::MAX_ACCESSES_DEF,
    parameter int TYPE_ID_BITS = htk_pkg::TYPE_ID_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  htk_pkg::htk_cmd_t                 cmd,
    output htk_pkg::htk_stat_t                stat,
    input  logic [htk_pkg::TYPE_ID_W-1:0]     type_id,
    input  logic                              is_write,
    output logic [htk_pkg::INDEX_W-1:0]       task_index,
    output logic [htk_pkg::MASK_W-1:0]        predecessor_mask,
    output logic [htk_pkg::STATUS_W-1:0]      status
);

    localparam int TW    = TYPE_ID_BITS;
    localparam int TCW   = $clog2(MAX_TASKS + 1);
    localparam int AW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_ACCESSES + 1);
    localparam int ROW_W = CW + MAX_ACCESSES + MAX_ACCESSES * TW;

    // open task, one lane per access entry
    logic [MAX_ACCESSES-1:0][TW-1:0] lane_type_reg;
    logic [MAX_ACCESSES-1:0]         lane_write_reg;
    logic [CW-1:0]                   open_count_reg, open_count_next;

    logic [TCW-1:0] task_count_reg, task_count_next;
    logic           overflow_reg, overflow_next;
    logic [AW-1:0]  scan_ptr_reg, scan_ptr_next;
    logic           rd_valid_reg;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;

    logic [htk_pkg::MASK_W-1:0]   mask_reg, mask_next;
    logic [htk_pkg::INDEX_W-1:0]  res_index_reg;
    logic [htk_pkg::STATUS_W-1:0] res_status_reg;
    logic [htk_pkg::INDEX_W-1:0]  out_index_reg;
    logic [htk_pkg::MASK_W-1:0]   out_mask_reg;
    logic [htk_pkg::STATUS_W-1:0] out_status_reg;

    logic [31:0]             tid_ext;
    logic [TW-1:0]           key;
    logic [6:0]              tc_ext;
    logic [6:0]              rd_ptr_ext;
    logic [MAX_ACCESSES-1:0] lane_valid;
    logic [MAX_ACCESSES-1:0] hit;
    logic                    any_hit;
    logic                    has_room;

    logic [ROW_W-1:0]                wr_row;
    logic [ROW_W-1:0]                rd_row;
    logic [CW-1:0]                   row_count;
    logic [MAX_ACCESSES-1:0]         row_write;
    logic [MAX_ACCESSES-1:0][TW-1:0] row_type;
    logic                            row_conflict;

    assign tid_ext    = 32'(type_id);
    assign key        = tid_ext[TW-1:0];
    assign tc_ext     = 7'(task_count_reg);
    assign rd_ptr_ext = 7'(rd_ptr_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_ACCESSES; i++)
        begin
            lane_valid[i] = CW'(i) < open_count_reg;
            hit[i]        = lane_valid[i] && (lane_type_reg[i] == key);
        end
    end

    assign any_hit  = |hit;
    assign has_room = open_count_reg < CW'(MAX_ACCESSES);

    // task table row: count, write flags, type ids
    assign wr_row    = {open_count_reg, lane_write_reg, lane_type_reg};
    assign row_count = rd_row[ROW_W-1 -: CW];
    assign row_write = rd_row[MAX_ACCESSES*TW +: MAX_ACCESSES];
    assign row_type  = rd_row[MAX_ACCESSES*TW-1:0];

    htk_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (task_count_reg[AW-1:0]),
        .wr_data (wr_row),
        .rd_en   (cmd.rd_issue),
        .rd_addr (scan_ptr_reg),
        .rd_data (rd_row)
    );

    // all-pairs compare of one stored row against the open task
    always_comb
    begin
        row_conflict = 1'b0;
        for (int i = 0; i < MAX_ACCESSES; i++)
        begin
            for (int j = 0; j < MAX_ACCESSES; j++)
            begin
                if (lane_valid[i] && (CW'(j) < row_count)
                    && (lane_type_reg[i] == row_type[j])
                    && (lane_write_reg[i] || row_write[j]))
                begin
                    row_conflict = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.close_start || cmd.close_full)
        begin
            mask_next = '0;
        end
        else if (rd_valid_reg && row_conflict && (rd_ptr_ext < 7'd32))
        begin
            mask_next[rd_ptr_ext[4:0]] = 1'b1;
        end
    end

    always_comb
    begin
        task_count_next = task_count_reg;
        open_count_next = open_count_reg;
        overflow_next   = overflow_reg;
        scan_ptr_next   = scan_ptr_reg;
        rd_ptr_next     = cmd.rd_issue ? scan_ptr_reg : rd_ptr_reg;
        if (cmd.clear)
        begin
            task_count_next = '0;
            open_count_next = '0;
            overflow_next   = 1'b0;
        end
        if (cmd.add && !any_hit)
        begin
            if (has_room)
            begin
                open_count_next = open_count_reg + CW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.close_full)
        begin
            overflow_next = 1'b0;
        end
        if (cmd.close_start)
        begin
            scan_ptr_next = '0;
        end
        if (cmd.rd_issue)
        begin
            scan_ptr_next = scan_ptr_reg + AW'(1);
        end
        if (cmd.store)
        begin
            task_count_next = task_count_reg + TCW'(1);
            open_count_next = '0;
            overflow_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            open_count_reg <= '0;
            overflow_reg   <= 1'b0;
            scan_ptr_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            task_count_reg <= task_count_next;
            open_count_reg <= open_count_next;
            overflow_reg   <= overflow_next;
            scan_ptr_reg   <= scan_ptr_next;
            rd_valid_reg   <= cmd.rd_issue;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    // payload: lanes, staged result, output register
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            for (int i = 0; i < MAX_ACCESSES; i++)
            begin
                if (hit[i])
                begin
                    lane_write_reg[i] <= lane_write_reg[i] | is_write;
                end
                else if (!any_hit && has_room && (CW'(i) == open_count_reg))
                begin
                    lane_type_reg[i]  <= key;
                    lane_write_reg[i] <= is_write;
                end
            end
        end
        mask_reg <= mask_next;
        if (cmd.close_full)
        begin
            res_index_reg  <= '0;
            res_status_reg <= htk_pkg::STATUS_FULL;
        end
        if (cmd.store)
        begin
            res_index_reg  <= tc_ext[4:0];
            res_status_reg <= overflow_reg ? htk_pkg::STATUS_OVERFLOW : htk_pkg::STATUS_OK;
        end
        if (cmd.load_out)
        begin
            out_index_reg  <= res_index_reg;
            out_mask_reg   <= mask_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.full      = task_count_reg == TCW'(MAX_TASKS);
    assign stat.tc_zero   = task_count_reg == '0;
    assign stat.scan_last = (7'(scan_ptr_reg) + 7'd1) == tc_ext;

    assign task_index       = out_index_reg;
    assign predecessor_mask = out_mask_reg;
    assign status           = out_status_reg;

    a_tc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        task_count_reg <= TCW'(MAX_TASKS))
        else $error("task count above table depth");

    a_store_opens_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> (open_count_reg == '0) && !overflow_reg
                      && (task_count_reg == $past(task_count_reg) + TCW'(1)))
        else $error("store did not open a fresh row");

    a_no_add_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !cmd.add && !cmd.store)
        else $error("row update with task table full");

endmodule

@@ hw/rtl/htk_ctrl.sv @@
// Controller state machine: input decode, close scan sequencing, output valid.
// Depends on htk_pkg.
module htk_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [htk_pkg::REQ_W-1:0]     req_type,
    output logic                          in_stall,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  htk_pkg::htk_stat_t            stat,
    output htk_pkg::htk_cmd_t             cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_STORE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (htk_pkg::req_t'(req_type))
                        htk_pkg::REQ_ADD:
                        begin
                            cmd.add = !stat.full;
                        end
                        htk_pkg::REQ_CLOSE:
                        begin
                            if (stat.full)
                            begin
                                cmd.close_full = 1'b1;
                                state_next     = ST_EMIT;
                            end
                            else
                            begin
                                cmd.close_start = 1'b1;
                                state_next      = stat.tc_zero ? ST_STORE : ST_SCAN;
                            end
                        end
                        htk_pkg::REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == htk_pkg::REQ_CLOSE) |=> in_stall)
        else $error("close transaction did not hold off the input");

    a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg || !out_stall)
        else $error("result loaded over a pending transaction");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> !stat.tc_zero && !stat.full)
        else $error("table scan with no stored tasks");

endmodule

@@ hw/rtl/task_rw_hazard_dependency_tracker_top.sv @@
// Read/write hazard dependency tracker, top level.
// Depends on htk_pkg, htk_ram, htk_datapath and htk_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall, fields req_type, type_id, is_write)
//   carries one transaction per request: add an access to the open task,
//   close the open task, or clear all tables. Code 3 is taken and ignored.
//   Output channel (out_valid / out_stall) carries one transaction per close:
//   task_index, predecessor_mask (earlier tasks sharing a type where either
//   side writes) and status (ok, access list overflowed, task table full).
// Timing:
//   Add, clear and ignored requests never raise in_stall. Accesses merge in
//   parallel against the open task's lanes, so adds run back to back.
//   A close steps through the scan, drain, store and emit states to result
//   valid (scan and drain skipped for the first task, only emit when the
//   table is full): the task table RAM is scanned one stored row per cycle,
//   all entry pairs compared in parallel. in_stall stays high from a close
//   until its result is in the output register.
// Reset: empties the task table; memory contents stay undefined but are
//   never read past a row's stored count. No clearing pass is needed.
// Stall: a waiting result sits in the output register; adds and clears are
//   still taken, and a following close holds until the register frees up.
module task_rw_hazard_dependency_tracker_top #(
    parameter int MAX_TASKS    = htk_pkg::MAX_TASKS_DEF,
    parameter int MAX_ACCESSES = htk_pkg::MAX_ACCESSES_DEF,
    parameter int TYPE_ID_BITS = htk_pkg::TYPE_ID_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [htk_pkg::REQ_W-1:0]      req_type,
    input  logic [htk_pkg::TYPE_ID_W-1:0]  type_id,
    input  logic                           is_write,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [htk_pkg::INDEX_W-1:0]    task_index,
    output logic [htk_pkg::MASK_W-1:0]     predecessor_mask,
    output logic [htk_pkg::STATUS_W-1:0]   status
);

    htk_pkg::htk_cmd_t  cmd;
    htk_pkg::htk_stat_t stat;

    // sequencing: decode, scan, store, result handoff
    htk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // lanes, task table, conflict compare and result registers
    htk_datapath #(
        .MAX_TASKS    (MAX_TASKS),
        .MAX_ACCESSES (MAX_ACCESSES),
        .TYPE_ID_BITS (TYPE_ID_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .type_id          (type_id),
        .is_write         (is_write),
        .task_index       (task_index),
        .predecessor_mask (predecessor_mask),
        .status           (status)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the read/write hazard dependency tracker.
// Depends on htk_pkg and task_rw_hazard_dependency_tracker_top (default parameters).
`timescale 1ns / 1ps

module tb;

    // ------------------------------------------------------------------
    // Sizes and run control
    // ------------------------------------------------------------------
    localparam int REQ_W        = htk_pkg::REQ_W;
    localparam int TYPE_ID_W    = htk_pkg::TYPE_ID_W;
    localparam int INDEX_W      = htk_pkg::INDEX_W;
    localparam int MASK_W       = htk_pkg::MASK_W;
    localparam int STATUS_W     = htk_pkg::STATUS_W;
    localparam int TASKS        = htk_pkg::MAX_TASKS_DEF;
    localparam int LANES        = htk_pkg::MAX_ACCESSES_DEF;
    localparam int TOTAL_ITEMS  = 1100;
    // Worst case is far below this: about 1100 transactions, each close at
    // most a full table scan plus an input gap and an output stall.
    localparam int LIMIT_CYCLES = 400000;
    // Slowest close scans 31 stored rows; leave margin.
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    // Code 3 has no name in the package; the block takes and drops it.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0]  task_idx;
        logic [MASK_W-1:0]   hazards;
        logic [STATUS_W-1:0] status;
    } close_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic [TYPE_ID_W-1:0] tid;
        logic                 wr;
        logic                 typed;  // expected result given in the row
        close_result_t        want;
    } script_row_t;

    // ------------------------------------------------------------------
    // Directed script. Rows with typed=1 carry a result that is obvious
    // from the spec; every other close is checked against the predictor.
    // ------------------------------------------------------------------
    localparam int SCRIPT_ROWS = 25;
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // empty task right after reset: row 0, no hazards
        '{htk_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b1, '{5'd0, 32'h0, htk_pkg::STATUS_OK}},
        // type id extremes, write on 0xFFFF
        '{htk_pkg::REQ_ADD,   16'hFFFF, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0000, 1'b0, 1'b0, '0},
        // only earlier task is empty, so nothing to depend on
        '{htk_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b1, '{5'd1, 32'h0, htk_pkg::STATUS_OK}},
        // read after write on 0xFFFF, read/read on 0 is no hazard
        '{htk_pkg::REQ_ADD,   16'hFFFF, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0000, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b0, '0},
        // repeated id merges, write overrides read
        '{htk_pkg::REQ_ADD,   16'h1234, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h1234, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0000, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0001, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0002, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0004, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h8000, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h5555, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'hAAAA, 1'b0, 1'b0, '0},
        // list is full: new id dropped, known id still merged
        '{htk_pkg::REQ_ADD,   16'h7777, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_ADD,   16'h0001, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b0, '0},
        // read of a type written by the overflowed task
        '{htk_pkg::REQ_ADD,   16'h1234, 1'b0, 1'b0, '0},
        // unused code with all bits set, must be dropped silently
        '{REQ_UNUSED,         16'hFFFF, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b0, '0},
        // clear with an open task pending, then a fresh empty task
        '{htk_pkg::REQ_ADD,   16'h0003, 1'b1, 1'b0, '0},
        '{htk_pkg::REQ_CLEAR, 16'h0000, 1'b0, 1'b0, '0},
        '{htk_pkg::REQ_CLOSE, 16'h0000, 1'b0, 1'b1, '{5'd0, 32'h0, htk_pkg::STATUS_OK}}
    };

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type;
    logic [TYPE_ID_W-1:0] type_id;
    logic                 is_write;
    logic                 out_valid;
    logic                 out_stall;
    logic [INDEX_W-1:0]   task_index;
    logic [MASK_W-1:0]    predecessor_mask;
    logic [STATUS_W-1:0]  status;

    task_rw_hazard_dependency_tracker_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .type_id          (type_id),
        .is_write         (is_write),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .task_index       (task_index),
        .predecessor_mask (predecessor_mask),
        .status           (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the task table as the block should hold it
    // ------------------------------------------------------------------
    logic [TYPE_ID_W-1:0] row_type [TASKS][LANES];
    logic                 row_wr   [TASKS][LANES];
    int unsigned          row_len  [TASKS];
    int unsigned          stored_tasks;
    bit                   access_dropped;

    close_result_t pending_results [$];

    int unsigned useful_items;
    int unsigned close_count, overflow_closes, full_closes, clear_count;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          quiet_tail;

    logic [TYPE_ID_W-1:0] id_pool [12];

    function automatic void forget_tasks();
        for (int t = 0; t < TASKS; t++)
            row_len[t] = 0;
        stored_tasks   = 0;
        access_dropped = 1'b0;
    endfunction

    // Applies one accepted transaction to the predicted table; on a close,
    // returns the result the block must produce.
    function automatic void hazard_predict(input logic [REQ_W-1:0] req,
                                           input logic [TYPE_ID_W-1:0] tid,
                                           input logic wr,
                                           output bit produced,
                                           output close_result_t res);
        int unsigned cur;
        int unsigned len;
        bit          hit;
        produced = 1'b0;
        res      = '0;
        cur      = stored_tasks;
        case (req)
            htk_pkg::REQ_ADD:
            begin
                // table full: accesses go nowhere
                if (cur < TASKS)
                begin
                    len = row_len[cur];
                    hit = 1'b0;
                    for (int k = 0; k < len; k++)
                    begin
                        if (row_type[cur][k] == tid)
                        begin
                            hit = 1'b1;
                            if (wr)
                                row_wr[cur][k] = 1'b1;
                        end
                    end
                    if (!hit)
                    begin
                        if (len < LANES)
                        begin
                            row_type[cur][len] = tid;
                            row_wr[cur][len]   = wr;
                            row_len[cur]       = len + 1;
                        end
                        else
                            access_dropped = 1'b1;
                    end
                end
            end
            htk_pkg::REQ_CLOSE:
            begin
                produced = 1'b1;
                close_count++;
                if (cur >= TASKS)
                begin
                    res.status = htk_pkg::STATUS_FULL;
                    full_closes++;
                end
                else
                begin
                    // earlier row p is a predecessor if any shared type is
                    // written on either side
                    for (int p = 0; p < cur; p++)
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < row_len[p]; i++)
                            for (int j = 0; j < row_len[cur]; j++)
                                if (row_type[p][i] == row_type[cur][j] &&
                                    (row_wr[p][i] || row_wr[cur][j]))
                                    hit = 1'b1;
                        if (hit && p < MASK_W)
                            res.hazards[p] = 1'b1;
                    end
                    res.task_idx = cur[INDEX_W-1:0];
                    res.status   = access_dropped ? htk_pkg::STATUS_OVERFLOW
                                                  : htk_pkg::STATUS_OK;
                    if (access_dropped)
                        overflow_closes++;
                    stored_tasks = cur + 1;
                    if (stored_tasks < TASKS)
                        row_len[stored_tasks] = 0;
                end
                access_dropped = 1'b0;
            end
            htk_pkg::REQ_CLEAR:
            begin
                clear_count++;
                forget_tasks();
            end
            default:
                ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what,
                                          input logic [MASK_W-1:0] want,
                                          input logic [MASK_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Mostly ids from a small pool so that tasks actually collide; the rest
    // are fresh random ids to walk every bit of type_id.
    function automatic logic [TYPE_ID_W-1:0] pick_type();
        if ($urandom_range(0, 3) != 0)
            return id_pool[$urandom_range(0, 11)];
        return TYPE_ID_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Input driver. Called at a falling edge; returns at the falling edge
    // after the transaction was taken. Valid stays high between
    // back-to-back transactions and only drops for an idle burst.
    // ------------------------------------------------------------------
    task automatic issue_request(input logic [REQ_W-1:0] req,
                                 input logic [TYPE_ID_W-1:0] tid,
                                 input logic wr,
                                 input bit typed,
                                 input close_result_t typed_res);
        int unsigned   gap;
        bit            produced;
        close_result_t res;
        if (!quiet_tail && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        type_id  <= tid;
        is_write <= wr;
        // taken at the first rising edge with stall low
        do
            @(posedge clk);
        while (in_stall);
        if (!(req == REQ_UNUSED || (req == htk_pkg::REQ_ADD && stored_tasks >= TASKS)))
            useful_items++;
        hazard_predict(req, tid, wr, produced, res);
        if (produced)
            pending_results.insert(pending_results.size(), typed ? typed_res : res);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, with calm stretches in between
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_tail)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    // calm stretch, no back-pressure
                    n = $urandom_range(20, 80);
                    repeat (n) @(negedge clk);
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, 10);
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each taken result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        close_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result, task_index", '0, MASK_W'(task_index));
            else
            begin
                want = pending_results.pop_front();
                if (task_index !== want.task_idx)
                    flag_mismatch("task_index", MASK_W'(want.task_idx),
                                  MASK_W'(task_index));
                if (predecessor_mask !== want.hazards)
                    flag_mismatch("predecessor_mask", want.hazards, predecessor_mask);
                if (status !== want.status)
                    flag_mismatch("status", MASK_W'(want.status), MASK_W'(status));
            end
        end
    end

    // Cycle counter and hard stop
    initial
    begin
        cycle_count = 0;
        repeat (LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned roll;
        int unsigned n_acc;
        // known values on every input from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = htk_pkg::REQ_ADD;
        type_id   = '0;
        is_write  = 1'b0;
        quiet_tail      = 1'b0;
        useful_items    = 0;
        close_count     = 0;
        overflow_closes = 0;
        full_closes     = 0;
        clear_count     = 0;
        mismatches      = 0;
        forget_tasks();

        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 12; i++)
            id_pool[i] = TYPE_ID_W'($urandom);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        for (int r = 0; r < SCRIPT_ROWS; r++)
            issue_request(SCRIPT[r].req, SCRIPT[r].tid, SCRIPT[r].wr,
                          SCRIPT[r].typed, SCRIPT[r].want);

        // random part: mostly whole tasks (accesses then close), some clears
        // to leave the full-table state, and a little noise
        while (useful_items < TOTAL_ITEMS)
        begin
            quiet_tail = (useful_items >= TOTAL_ITEMS * 85 / 100);
            roll = $urandom_range(0, 99);
            if (roll < 2 || (stored_tasks >= TASKS && roll < 35))
                issue_request(htk_pkg::REQ_CLEAR, TYPE_ID_W'($urandom), 1'($urandom),
                              1'b0, '0);
            else if (roll < 5)
                issue_request(REQ_UNUSED, TYPE_ID_W'($urandom), 1'($urandom), 1'b0, '0);
            else if (roll < 8)
                issue_request(htk_pkg::REQ_CLOSE, TYPE_ID_W'($urandom), 1'($urandom),
                              1'b0, '0);
            else
            begin
                // some tasks run past the access list to force overflow
                if ($urandom_range(0, 99) < 12)
                    n_acc = $urandom_range(LANES + 1, LANES + 4);
                else
                    n_acc = $urandom_range(0, 6);
                for (int k = 0; k < n_acc; k++)
                    issue_request(htk_pkg::REQ_ADD, pick_type(), ($urandom_range(0, 9) < 4),
                                  1'b0, '0);
                issue_request(htk_pkg::REQ_CLOSE, TYPE_ID_W'($urandom), 1'($urandom),
                              1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // drain, then let the pipeline settle to catch stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transactions applied, %0d closes (%0d overflowed, %0d on a full table),",
                 useful_items, close_count, overflow_closes, full_closes);
        $display("%0d clears, %0d mismatches, %0d cycles", clear_count, mismatches, cycle_count);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
